// ----- hw/rtl/kss_pkg.sv -----
package kss_pkg;

    // Default number of cells in the sorting chain, one element per cell.
    localparam int DEFAULT_STORE_DEPTH = 1024;

    localparam int ELEM_W = 32;
    localparam int RANK_W = 11;

    typedef logic signed [ELEM_W-1:0] elem_t;
    typedef logic [RANK_W-1:0]        rank_t;

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_RANK     = 2'd1,
        STATUS_OVERFLOW = 2'd2
    } status_t;

    // Commands broadcast to every cell of the chain.
    typedef struct packed {
        logic insert;
        logic shift;
    } cell_ctrl_t;

endpackage

// ----- hw/rtl/kth_smallest_select.sv -----
// Loading: one element per cycle while s_tready is high; each transfer that finds room in
// the chain is sorted into it on its accept edge. Selection: after the last transfer, the
// chain shifts towards its head target_rank - 1 times and the head is registered once the
// output is free. An error result (bad rank or overflow) is registered on the last transfer.
// Reset: synchronous on aresetn low; clears the count, overflow flag and handshake state,
// and sets target_rank to 1. Element storage is not cleared and needs no clearing pass.
module kth_smallest_select #(
    parameter int STORE_DEPTH = kss_pkg::DEFAULT_STORE_DEPTH
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_we,
    input  logic [10:0] cfg_wdata,     // target_rank

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,       // [31:0] element_value
    input  logic        s_tlast,       // last_element

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,       // [31:0] selected_value
    output logic [1:0]  m_tuser        // [1:0] status
);
    import kss_pkg::*;

    localparam int CNT_W = $clog2(STORE_DEPTH + 1);
    // Width wide enough to compare the rank register against the fill count.
    localparam int CMP_W = (CNT_W > RANK_W) ? CNT_W : RANK_W;

    typedef enum logic [1:0] {
        ST_LOAD   = 2'b01,
        ST_SELECT = 2'b10
    } state_t;

    state_t           state_reg,    state_next;
    logic [CNT_W-1:0] count_reg,    count_next;
    logic             overflow_reg, overflow_next;
    rank_t            rank_reg,     rank_next;
    logic [CNT_W-1:0] shift_reg,    shift_next;
    logic             m_valid_reg,  m_valid_next;
    elem_t            m_value_reg,  m_value_next;
    status_t          m_status_reg, m_status_next;

    logic             s_transfer;
    logic             out_free;
    logic             room;
    logic [CNT_W-1:0] count_after;
    logic             overflow_after;
    logic [CMP_W-1:0] rank_wide;
    logic             bad_rank;
    cell_ctrl_t       ctrl;
    elem_t            head_value;

    // The output register parts the two sides: loading carries on while a
    // result waits, and only a closing transfer has to wait for it to drain.
    assign out_free   = !m_valid_reg || m_tready;
    assign s_tready   = (state_reg == ST_LOAD) && (!s_tlast || out_free);
    assign s_transfer = s_tvalid && s_tready;

    // Once the chain is full further elements are dropped and overflow is noted.
    assign room           = count_reg < CNT_W'(STORE_DEPTH);
    assign count_after    = room ? count_reg + 1'b1 : count_reg;
    assign overflow_after = overflow_reg || !room;

    assign rank_wide = CMP_W'(rank_reg);
    assign bad_rank  = (rank_reg == '0) || (rank_wide > CMP_W'(count_after));

    assign ctrl.insert = s_transfer && room;
    assign ctrl.shift  = (state_reg == ST_SELECT) && (shift_reg != '0);

    kss_chain #(
        .STORE_DEPTH (STORE_DEPTH),
        .CNT_W       (CNT_W)
    ) u_chain (
        .aclk         (aclk),
        .ctrl         (ctrl),
        .insert_value (elem_t'(s_tdata)),
        .fill_count   (count_reg),
        .head_value   (head_value)
    );

    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        overflow_next = overflow_reg;
        rank_next     = rank_reg;
        shift_next    = shift_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        m_value_next  = m_value_reg;
        m_status_next = m_status_reg;

        if (cfg_we) begin
            rank_next = cfg_wdata;
        end

        unique case (state_reg)
            ST_LOAD: begin
                if (s_transfer) begin
                    count_next    = count_after;
                    overflow_next = overflow_after;
                    if (s_tlast) begin
                        if (overflow_after) begin
                            m_valid_next  = 1'b1;
                            m_value_next  = '0;
                            m_status_next = STATUS_OVERFLOW;
                            count_next    = '0;
                            overflow_next = 1'b0;
                        end else if (bad_rank) begin
                            m_valid_next  = 1'b1;
                            m_value_next  = '0;
                            m_status_next = STATUS_RANK;
                            count_next    = '0;
                            overflow_next = 1'b0;
                        end else begin
                            // Rank minus one shifts bring the wanted element to the head.
                            shift_next = CNT_W'(rank_wide - 1'b1);
                            state_next = ST_SELECT;
                        end
                    end
                end
            end
            ST_SELECT: begin
                if (shift_reg != '0) begin
                    shift_next = shift_reg - 1'b1;
                end else if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_value_next  = head_value;
                    m_status_next = STATUS_OK;
                    count_next    = '0;
                    overflow_next = 1'b0;
                    state_next    = ST_LOAD;
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_LOAD;
            count_reg    <= '0;
            overflow_reg <= 1'b0;
            rank_reg     <= RANK_W'(1);
            shift_reg    <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            overflow_reg <= overflow_next;
            rank_reg     <= rank_next;
            shift_reg    <= shift_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_value_reg  <= m_value_next;
        m_status_reg <= m_status_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_value_reg;
    assign m_tuser  = m_status_reg;

endmodule

// ----- hw/rtl/kss_cell.sv -----
module kss_cell #(
    parameter int CNT_W = 11,
    parameter int INDEX = 0
) (
    input  logic                aclk,
    input  kss_pkg::cell_ctrl_t ctrl,
    input  kss_pkg::elem_t      insert_value,
    input  logic [CNT_W-1:0]    fill_count,
    input  kss_pkg::elem_t      left_value,
    input  logic                left_gt,
    input  kss_pkg::elem_t      right_value,
    output kss_pkg::elem_t      cell_value,
    output logic                cell_gt
);
    import kss_pkg::*;

    elem_t value_reg;
    elem_t value_next;
    logic  occupied;

    // The chain stays sorted ascending with the unused cells at the far end,
    // so the cells whose value exceeds the newcomer form one contiguous tail.
    assign occupied = CNT_W'(INDEX) < fill_count;
    assign cell_gt  = !occupied || (insert_value < value_reg);

    always_comb begin
        value_next = value_reg;
        if (ctrl.insert && cell_gt) begin
            value_next = left_gt ? left_value : insert_value;
        end else if (ctrl.shift) begin
            value_next = right_value;
        end
    end

    always_ff @(posedge aclk) begin
        value_reg <= value_next;
    end

    assign cell_value = value_reg;

endmodule

// ----- hw/rtl/kss_chain.sv -----
module kss_chain #(
    parameter int STORE_DEPTH = kss_pkg::DEFAULT_STORE_DEPTH,
    parameter int CNT_W       = $clog2(STORE_DEPTH + 1)
) (
    input  logic                aclk,
    input  kss_pkg::cell_ctrl_t ctrl,
    input  kss_pkg::elem_t      insert_value,
    input  logic [CNT_W-1:0]    fill_count,
    output kss_pkg::elem_t      head_value
);
    import kss_pkg::*;

    elem_t values [STORE_DEPTH];
    logic  gts    [STORE_DEPTH];

    for (genvar i = 0; i < STORE_DEPTH; i++) begin : g_cell
        elem_t left_value;
        logic  left_gt;
        elem_t right_value;

        if (i == 0) begin : g_first
            assign left_value = insert_value;
            assign left_gt    = 1'b0;
        end else begin : g_inner_left
            assign left_value = values[i-1];
            assign left_gt    = gts[i-1];
        end

        if (i == STORE_DEPTH - 1) begin : g_last
            assign right_value = values[i];
        end else begin : g_inner_right
            assign right_value = values[i+1];
        end

        kss_cell #(
            .CNT_W (CNT_W),
            .INDEX (i)
        ) u_cell (
            .aclk         (aclk),
            .ctrl         (ctrl),
            .insert_value (insert_value),
            .fill_count   (fill_count),
            .left_value   (left_value),
            .left_gt      (left_gt),
            .right_value  (right_value),
            .cell_value   (values[i]),
            .cell_gt      (gts[i])
        );
    end

    assign head_value = values[0];

endmodule
